@@ design/banded_alignment_traceback_top_macros.svh @@
// Assertion macros for the traceback block checker.
`ifndef BANDED_ALIGNMENT_TRACEBACK_TOP_MACROS_SVH
`define BANDED_ALIGNMENT_TRACEBACK_TOP_MACROS_SVH

// Check outside reset.
`define BAT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also spans reset.
`define BAT_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bat_pkg.sv @@
// Types and constants shared by the traceback block modules.
package bat_pkg;

  localparam int unsigned ROW_W    = 64;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = 2;

  localparam logic [ROW_W-1:0] PAT_01 = 64'h5555_5555_5555_5555;
  localparam logic [ROW_W-1:0] PAT_10 = 64'hAAAA_AAAA_AAAA_AAAA;

  // opcodes
  localparam logic [1:0] OP_DIR   = 2'd0;
  localparam logic [1:0] OP_FIRST = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // walk phase
  localparam logic [1:0] PH_UNKNOWN = 2'd0;
  localparam logic [1:0] PH_VERT    = 2'd1;
  localparam logic [1:0] PH_HORZ    = 2'd2;

  // arrows
  localparam logic [1:0] AR_ERR  = 2'd0;
  localparam logic [1:0] AR_UP   = 2'd1;
  localparam logic [1:0] AR_LEFT = 2'd2;
  localparam logic [1:0] AR_DIAG = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_DIR = 2'd1;
  localparam logic [1:0] ST_COUNT  = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // register indexes
  localparam logic REG_LENGTH_A = 1'b0;
  localparam logic REG_LENGTH_B = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ROW_W-1:0] arrow_row;
  } bat_in_t;

  typedef struct packed {
    logic             pair_valid;
    logic [LEN_W-1:0] index_a;
    logic [LEN_W-1:0] index_b;
    logic             gap_a;
    logic             gap_b;
    logic [1:0]       rows_back;
    logic [POS_W-1:0] next_arrow_pos;
    logic             done_res;
    logic [1:0]       status;
  } bat_out_t;

  // classified item between front and back
  typedef struct packed {
    logic [1:0]       op;
    logic [1:0]       dir;
    logic             first_any;
    logic             first_multi;
    logic [POS_W-1:0] first_hi;
    logic [1:0]       first_arrow;
    logic [ROW_W-1:0] row;
  } bat_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bat_qstat_t;

endpackage

@@ design/bat_front.sv @@
// Front end: masks the arrow row and classifies direction and first-row items.
module bat_front import bat_pkg::*; #(
  parameter int unsigned NUM_PES = 32
) (
  input  bat_in_t  item,
  output bat_cmd_t cmd
);

  localparam int unsigned ROW_BITS = 2 * NUM_PES;
  localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - ROW_BITS);

  logic [ROW_W-1:0] row_m;

  assign row_m = item.arrow_row & ROW_MASK;

  always_comb begin
    cmd             = '0;
    cmd.op          = item.opcode;
    cmd.row         = row_m;
    if (row_m == (PAT_01 & ROW_MASK)) begin
      cmd.dir = PH_VERT;
    end else if (row_m == (PAT_10 & ROW_MASK)) begin
      cmd.dir = PH_HORZ;
    end else begin
      cmd.dir = PH_UNKNOWN;
    end
    // highest nonzero arrow wins; flag a second one
    for (int e = 0; e < NUM_PES; e++) begin
      if (row_m[2*e +: 2] != AR_ERR) begin
        if (cmd.first_any) begin
          cmd.first_multi = 1'b1;
        end
        cmd.first_any   = 1'b1;
        cmd.first_hi    = POS_W'(2 * e);
        cmd.first_arrow = row_m[2*e +: 2];
      end
    end
  end

endmodule

@@ design/bat_queue.sv @@
// Short queue of classified items between front and back.
module bat_queue import bat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bat_cmd_t   push_data,
  input  logic       pop,
  output bat_cmd_t   head,
  output bat_qstat_t stat
);

  bat_cmd_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign stat.full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/bat_back.sv @@
// Back end: walk state, arrow decode and the result register.
module bat_back import bat_pkg::*; #(
  parameter int unsigned NUM_PES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] length_a,
  input  logic [LEN_W-1:0] length_b,
  input  bat_cmd_t         head,
  input  bat_qstat_t       qstat,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output bat_out_t         result
);

  localparam logic [POS_W:0] LAST_POS = (POS_W+1)'(2 * NUM_PES - 2);

  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [LEN_W-1:0] remain_a;
  logic [LEN_W-1:0] remain_a_next;
  logic [LEN_W-1:0] remain_b;
  logic [LEN_W-1:0] remain_b_next;
  logic [POS_W-1:0] arrow_position;
  logic [POS_W-1:0] arrow_position_next;
  bat_out_t         res;

  logic             known;
  logic [1:0]       step_arrow;

  assign known      = (phase == PH_VERT) || (phase == PH_HORZ);
  assign step_arrow = 2'(head.row >> arrow_position);
  assign pop        = !qstat.empty && (!result_valid || result_ready);

  always_comb begin
    logic             do_dec;
    logic [1:0]       dec_arrow;
    logic [LEN_W-1:0] base_a;
    logic [LEN_W-1:0] base_b;
    logic [POS_W-1:0] base_pos;
    logic             move_up;
    logic             move_down;
    logic [POS_W:0]   np_up;

    phase_next          = phase;
    remain_a_next       = remain_a;
    remain_b_next       = remain_b;
    arrow_position_next = arrow_position;
    res                 = '0;
    do_dec              = 1'b0;
    dec_arrow           = head.first_arrow;
    base_a              = remain_a;
    base_b              = remain_b;
    base_pos            = arrow_position;
    move_up             = 1'b0;
    move_down           = 1'b0;
    np_up               = {1'b0, arrow_position} + (POS_W+1)'(2);

    case (head.op)
      OP_DIR: begin
        phase_next = head.dir;
        if (head.dir == PH_UNKNOWN) begin
          res.status = ST_NO_DIR;
        end
      end
      OP_FIRST: begin
        base_a              = length_a;
        base_b              = length_b;
        base_pos            = head.first_hi;
        remain_a_next       = length_a;
        remain_b_next       = length_b;
        arrow_position_next = head.first_hi;
        if (!head.first_any || head.first_multi) begin
          res.status = ST_COUNT;
        end
        if (!known) begin
          res.status = ST_NO_DIR;
        end else if (head.first_any && ((length_a != '0) || (length_b != '0))) begin
          do_dec = 1'b1;
        end
      end
      OP_STEP: begin
        dec_arrow = step_arrow;
        if (!known) begin
          res.status = ST_NO_DIR;
        end else if ((remain_a != '0) || (remain_b != '0)) begin
          if ({1'b0, arrow_position} > LAST_POS) begin
            res.status = ST_RANGE;
          end else begin
            do_dec = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_dec) begin
      // force the arrow once one sequence is used up
      if (base_a == '0) begin
        dec_arrow = AR_LEFT;
      end else if (base_b == '0) begin
        dec_arrow = AR_UP;
      end
      res.pair_valid = 1'b1;
      case (dec_arrow)
        AR_UP: begin
          res.rows_back = 2'd1;
          res.gap_b     = 1'b1;
          remain_a_next = base_a - 1'b1;
          move_down     = (phase == PH_HORZ);
          phase_next    = (phase == PH_VERT) ? PH_HORZ : PH_VERT;
        end
        AR_LEFT: begin
          res.rows_back = 2'd1;
          res.gap_a     = 1'b1;
          remain_b_next = base_b - 1'b1;
          move_up       = (phase == PH_VERT);
          phase_next    = (phase == PH_VERT) ? PH_HORZ : PH_VERT;
        end
        default: begin
          res.rows_back = (dec_arrow == AR_DIAG) ? 2'd2 : 2'd0;
          remain_a_next = base_a - 1'b1;
          remain_b_next = base_b - 1'b1;
        end
      endcase
      res.index_a = res.gap_a ? '0 : remain_a_next;
      res.index_b = res.gap_b ? '0 : remain_b_next;
      np_up = {1'b0, base_pos} + (POS_W+1)'(2);
      // keep the position when the move leaves the row
      if (move_up) begin
        if (np_up <= LAST_POS) begin
          arrow_position_next = np_up[POS_W-1:0];
        end else begin
          res.status = ST_RANGE;
        end
      end else if (move_down) begin
        if (base_pos >= POS_W'(2)) begin
          arrow_position_next = base_pos - POS_W'(2);
        end else begin
          res.status = ST_RANGE;
        end
      end
    end

    res.next_arrow_pos = arrow_position_next;
    res.done_res       = (remain_a_next == '0) && (remain_b_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_UNKNOWN;
      remain_a       <= '0;
      remain_b       <= '0;
      arrow_position <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase          <= phase_next;
        remain_a       <= remain_a_next;
        remain_b       <= remain_b_next;
        arrow_position <= arrow_position_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

endmodule

@@ design/banded_alignment_traceback_top.sv @@
// Top level of the traceback block: configuration registers, front, queue and back.
// An accepted item is registered in the queue, and its result is registered when the back end pops it.
// Throughput: one item per cycle while results are taken; the walk-state update in the back end sets it.
// A four-entry queue lets the input side run ahead while a result waits to be taken.
// Reset (synchronous, active high) clears lengths, walk state, queue and result valid.
module banded_alignment_traceback_top import bat_pkg::*; #(
  parameter int unsigned NUM_PES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  bat_in_t           item,
  output logic              result_valid,
  input  logic              result_ready,
  output bat_out_t          result
);

  logic [LEN_W-1:0] length_a;
  logic [LEN_W-1:0] length_b;
  logic             reg_sel;
  bat_cmd_t         cmd;
  bat_cmd_t         head;
  bat_qstat_t       qstat;
  logic             push;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_LENGTH_B) ? DATA_W'(length_b) : DATA_W'(length_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      length_a <= '0;
      length_b <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_LENGTH_A: length_a <= pwdata[LEN_W-1:0];
        REG_LENGTH_B: length_b <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item_ready = !qstat.full;
  assign push       = item_valid && item_ready;

  bat_front #(.NUM_PES(NUM_PES)) u_front (
    .item (item),
    .cmd  (cmd)
  );

  bat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  bat_back #(.NUM_PES(NUM_PES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .length_a     (length_a),
    .length_b     (length_b),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ design/bat_checker.sv @@
// Port-level checker for the traceback block and its bind.
`include "banded_alignment_traceback_top_macros.svh"

module bat_checker import bat_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input bat_out_t          result
);

  `BAT_CHECK_RST(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")

  `BAT_CHECK(a_result_holds,
    result_valid && !result_ready |=> result_valid && $stable(result),
    "stalled result changed")

  `BAT_CHECK(a_empty_column,
    result_valid && !result.pair_valid |-> result.index_a == '0 && result.index_b == '0
      && !result.gap_a && !result.gap_b && result.rows_back == 2'd0,
    "fields set without a column")

  `BAT_CHECK(a_column_shape,
    result_valid && result.pair_valid |-> !(result.gap_a && result.gap_b)
      && result.status != ST_NO_DIR
      && ((result.gap_a || result.gap_b) ? result.rows_back == 2'd1 : result.rows_back != 2'd1),
    "inconsistent column")

endmodule

bind banded_alignment_traceback_top bat_checker u_bat_checker (.*);
